@@ design/mlfq_pkg.sv @@
`timescale 1ns / 1ps
package mlfq_pkg;

  localparam int unsigned LevelMin = 3;
  localparam int unsigned LevelMax = 8;
  localparam int unsigned TaskMax = 16;
  localparam int unsigned CntMax = 255;
  localparam int unsigned TickMax = 65535;

  typedef enum logic [1:0] {
    CfgLevelCount = 2'd0,
    CfgBoostPeriod = 2'd1,
    CfgQuantum = 2'd2,
    CfgAllotment = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StBoostScan,
    StBoostPop,
    StBoostPush,
    StBoostHeld,
    StHeldRd,
    StHeldChk,
    StPickScan,
    StPickRd,
    StRun,
    StDone
  } state_e;

endpackage

@@ design/mlfq_task_scheduler.sv @@
`timescale 1ns / 1ps
// An arrival item is written in StIdle and ends in StDone. A tick item passes StHeldRd,
// StHeldChk if a task is held, StPickScan and StPickRd if a new task is picked, StRun, StDone.
// A boost pops each queued task of the levels in use, then pushes each back onto level 0.
// Items are taken one at a time; busy is high while an item is worked on, and the queue
// memory is walked one entry at a time by a single sequencer.
// Reset clears all control state; the receiver cannot stall, so each result is shown
// on the result ports for one cycle with valid_o high.
module mlfq_task_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        kind_i,
  input  logic [3:0]  task_id_i,
  input  logic [15:0] burst_i,
  output logic        valid_o,
  output logic [3:0]  ran_task_o,
  output logic        idle_o,
  output logic        finished_o,
  output logic        demoted_o,
  output logic [2:0]  ran_level_o,
  output logic        boosted_o
);
  import mlfq_pkg::*;

  localparam int unsigned TW = (TaskMax > 1) ? $clog2(TaskMax) : 1;
  localparam int unsigned LW = $clog2(LevelMax);
  localparam int unsigned CW = $clog2(TaskMax + 1);

  // Configuration registers.
  logic [3:0]  lvl_cnt_q;
  logic [15:0] boost_per_q;
  logic [63:0] quant_q, allot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_cnt_q <= 4'(LevelMin);
      boost_per_q <= '0;
      quant_q <= '0;
      allot_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgLevelCount: lvl_cnt_q <= cfg_data_i[3:0];
        CfgBoostPeriod: boost_per_q <= cfg_data_i[15:0];
        CfgQuantum: quant_q <= cfg_data_i;
        CfgAllotment: allot_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [3:0] levels;
  always_comb begin
    if (lvl_cnt_q < 4'(LevelMin)) levels = 4'(LevelMin);
    else if (lvl_cnt_q > 4'(LevelMax)) levels = 4'(LevelMax);
    else levels = lvl_cnt_q;
  end

  // Queue memory: one row of TaskMax entries per level.
  logic [TW-1:0] qmem [LevelMax*TaskMax];
  logic          qm_we;
  logic [LW+TW-1:0] qm_waddr, qm_raddr;
  logic [TW-1:0] qm_wdata, qm_rdata;
  always_ff @(posedge clk_i) begin
    if (qm_we) qmem[qm_waddr] <= qm_wdata;
    qm_rdata <= qmem[qm_raddr];
  end

  // Per-task memory: remaining, level, units at level.
  logic [15:0]    rem_mem [TaskMax];
  logic [LW-1:0]  lvl_mem [TaskMax];
  logic [7:0]     ual_mem [TaskMax];
  logic           tk_we;
  logic [TW-1:0]  tk_waddr, tk_raddr;
  logic [15:0]    tk_wrem, tk_rrem;
  logic [LW-1:0]  tk_wlvl, tk_rlvl;
  logic [7:0]     tk_wual, tk_rual;
  always_ff @(posedge clk_i) begin
    if (tk_we) begin
      rem_mem[tk_waddr] <= tk_wrem;
      lvl_mem[tk_waddr] <= tk_wlvl;
      ual_mem[tk_waddr] <= tk_wual;
    end
    tk_rrem <= rem_mem[tk_raddr];
    tk_rlvl <= lvl_mem[tk_raddr];
    tk_rual <= ual_mem[tk_raddr];
  end

  state_e state_q, state_d;
  logic [TW-1:0] head_q [LevelMax];
  logic [CW-1:0] cnt_q [LevelMax];
  logic [TaskMax-1:0] act_q, act_d;
  logic [TW-1:0] held_q, held_d;
  logic          hv_q, hv_d;
  logic [7:0]    turn_q, turn_d;
  logic [15:0]   tsb_q, tsb_d;
  logic [LW-1:0] lv_q, lv_d;
  logic [CW-1:0] bn_q, bn_d;   // tasks collected by boost
  logic [CW-1:0] bk_q, bk_d;   // boost push index
  logic [TW-1:0] bids_q [TaskMax];
  logic          bid_we;
  logic          boost_q, boost_d, dem_q, dem_d;

  // Queue operation requests applied in the clocked block.
  logic          push_en, pop_en;
  logic [LW-1:0] push_l, pop_l;

  logic [LevelMax-1:0] nz;
  always_comb begin
    for (int i = 0; i < LevelMax; i++) nz[i] = (cnt_q[i] != '0);
  end

  logic [7:0] allot_b, quant_b;
  assign allot_b = allot_q[8*tk_rlvl +: 8];
  assign quant_b = quant_q[8*tk_rlvl +: 8];

  logic higher, spent;
  always_comb begin
    higher = 1'b0;
    for (int i = 0; i < LevelMax; i++)
      if (LW'(i) < tk_rlvl && nz[i]) higher = 1'b1;
  end
  assign spent = (allot_b != 8'd0) && (tk_rual >= allot_b);

  logic id_ok;
  assign id_ok = ({1'b0, task_id_i} < 5'(TaskMax));

  always_comb begin
    state_d = state_q;
    act_d = act_q;
    held_d = held_q;
    hv_d = hv_q;
    turn_d = turn_q;
    tsb_d = tsb_q;
    lv_d = lv_q;
    bn_d = bn_q;
    bk_d = bk_q;
    boost_d = boost_q;
    dem_d = dem_q;
    push_en = 1'b0;
    push_l = '0;
    pop_en = 1'b0;
    pop_l = lv_q;
    bid_we = 1'b0;
    qm_we = 1'b0;
    qm_waddr = '0;
    qm_wdata = '0;
    qm_raddr = {lv_q, head_q[lv_q]};
    tk_we = 1'b0;
    tk_waddr = held_q;
    tk_raddr = held_q;
    tk_wrem = tk_rrem;
    tk_wlvl = tk_rlvl;
    tk_wual = tk_rual;
    valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        tk_raddr = held_q;
        if (start) begin
          boost_d = 1'b0;
          dem_d = 1'b0;
          if (!kind_i) begin
            if (id_ok && !act_q[task_id_i[TW-1:0]] && burst_i != 16'd0 &&
                cnt_q[0] < CW'(TaskMax)) begin
              act_d[task_id_i[TW-1:0]] = 1'b1;
              tk_we = 1'b1;
              tk_waddr = task_id_i[TW-1:0];
              tk_wrem = burst_i;
              tk_wlvl = '0;
              tk_wual = '0;
              push_en = 1'b1;
              push_l = '0;
              qm_we = 1'b1;
              qm_waddr = {LW'(0), TW'(head_q[0] + TW'(cnt_q[0]))};
              qm_wdata = task_id_i[TW-1:0];
            end else if (id_ok && !act_q[task_id_i[TW-1:0]] && burst_i != 16'd0) begin
              act_d[task_id_i[TW-1:0]] = 1'b1;
              tk_we = 1'b1;
              tk_waddr = task_id_i[TW-1:0];
              tk_wrem = burst_i;
              tk_wlvl = '0;
              tk_wual = '0;
            end
            state_d = StDone;
          end else if (boost_per_q != 16'd0 && tsb_q >= boost_per_q) begin
            boost_d = 1'b1;
            tsb_d = '0;
            lv_d = '0;
            bn_d = '0;
            state_d = StBoostScan;
          end else begin
            state_d = StHeldRd;
          end
        end
      end
      StBoostScan: begin
        // Pop every entry of levels in use, one per step, into a holding list.
        if ({1'b0, lv_q} < levels && nz[lv_q] && bn_q < CW'(TaskMax)) begin
          qm_raddr = {lv_q, head_q[lv_q]};
          pop_en = 1'b1;
          pop_l = lv_q;
          state_d = StBoostPop;
        end else if ({1'b0, lv_q} + 4'd1 < levels && bn_q < CW'(TaskMax)) begin
          lv_d = lv_q + LW'(1);
        end else begin
          bk_d = '0;
          state_d = StBoostPush;
        end
      end
      StBoostPop: begin
        bid_we = 1'b1;
        bn_d = bn_q + CW'(1);
        state_d = StBoostScan;
      end
      StBoostPush: begin
        if (bk_q < bn_q) begin
          tk_we = 1'b1;
          tk_waddr = bids_q[bk_q[TW-1:0]];
          tk_wlvl = '0;
          tk_wual = '0;
          tk_raddr = bids_q[bk_q[TW-1:0]];
          state_d = StBoostHeld;
        end else if (hv_q) begin
          state_d = StBoostHeld;
        end else begin
          state_d = StHeldRd;
        end
      end
      StBoostHeld: begin
        // Remaining-time field was read the cycle before; write it back unchanged.
        if (bk_q < bn_q) begin
          tk_we = 1'b1;
          tk_waddr = bids_q[bk_q[TW-1:0]];
          tk_wrem = tk_rrem;
          tk_wlvl = '0;
          tk_wual = '0;
          if (cnt_q[0] < CW'(TaskMax)) begin
            push_en = 1'b1;
            qm_we = 1'b1;
            qm_waddr = {LW'(0), TW'(head_q[0] + TW'(cnt_q[0]))};
            qm_wdata = bids_q[bk_q[TW-1:0]];
          end
          bk_d = bk_q + CW'(1);
          state_d = StBoostPush;
        end else begin
          tk_we = 1'b1;
          tk_waddr = held_q;
          tk_wrem = tk_rrem;
          tk_wlvl = '0;
          tk_wual = '0;
          if (cnt_q[0] < CW'(TaskMax)) begin
            push_en = 1'b1;
            qm_we = 1'b1;
            qm_waddr = {LW'(0), TW'(head_q[0] + TW'(cnt_q[0]))};
            qm_wdata = held_q;
          end
          hv_d = 1'b0;
          turn_d = '0;
          state_d = StHeldRd;
        end
      end
      StHeldRd: begin
        tk_raddr = held_q;
        state_d = hv_q ? StHeldChk : StPickScan;
        lv_d = '0;
      end
      StHeldChk: begin
        lv_d = '0;
        if (higher || spent || (quant_b != 8'd0 && turn_q >= quant_b)) begin
          push_l = tk_rlvl;
          if (spent && {1'b0, tk_rlvl} + 4'd1 < levels) begin
            push_l = tk_rlvl + LW'(1);
            tk_we = 1'b1;
            tk_wlvl = push_l;
            tk_wual = '0;
            dem_d = 1'b1;
          end
          if (cnt_q[push_l] < CW'(TaskMax)) begin
            push_en = 1'b1;
            qm_we = 1'b1;
            qm_waddr = {push_l, TW'(head_q[push_l] + TW'(cnt_q[push_l]))};
            qm_wdata = held_q;
          end
          hv_d = 1'b0;
          state_d = StPickScan;
        end else begin
          state_d = StRun;
        end
      end
      StPickScan: begin
        qm_raddr = {lv_q, head_q[lv_q]};
        if (nz[lv_q] && {1'b0, lv_q} < levels) begin
          pop_en = 1'b1;
          state_d = StPickRd;
        end else if ({1'b0, lv_q} + 4'd1 < levels) begin
          lv_d = lv_q + LW'(1);
        end else begin
          state_d = StRun;
        end
      end
      StPickRd: begin
        held_d = qm_rdata;
        hv_d = 1'b1;
        turn_d = '0;
        tk_raddr = qm_rdata;
        // A freshly picked task is never preempted in the same tick, so it runs at once.
        state_d = StRun;
      end
      StRun: begin
        tk_raddr = held_q;
        if (hv_q) begin
          tk_we = 1'b1;
          tk_wrem = (tk_rrem != 16'd0) ? tk_rrem - 16'd1 : tk_rrem;
          tk_wual = (tk_rual != 8'(CntMax)) ? tk_rual + 8'd1 : tk_rual;
          if (turn_q != 8'(CntMax)) turn_d = turn_q + 8'd1;
          if (tk_wrem == 16'd0) begin
            act_d[held_q] = 1'b0;
            hv_d = 1'b0;
          end
        end
        if (tsb_q != 16'(TickMax)) tsb_d = tsb_q + 16'd1;
        valid_o = 1'b1;
        state_d = StDone;
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      act_q <= '0;
      held_q <= '0;
      hv_q <= 1'b0;
      turn_q <= '0;
      tsb_q <= '0;
      lv_q <= '0;
      bn_q <= '0;
      bk_q <= '0;
      boost_q <= 1'b0;
      dem_q <= 1'b0;
      for (int i = 0; i < LevelMax; i++) begin
        head_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      act_q <= act_d;
      held_q <= held_d;
      hv_q <= hv_d;
      turn_q <= turn_d;
      tsb_q <= tsb_d;
      lv_q <= lv_d;
      bn_q <= bn_d;
      bk_q <= bk_d;
      boost_q <= boost_d;
      dem_q <= dem_d;
      for (int i = 0; i < LevelMax; i++) begin
        if (pop_en && pop_l == LW'(i) && push_en && push_l == LW'(i)) begin
          head_q[i] <= head_q[i] + TW'(1);
        end else if (pop_en && pop_l == LW'(i)) begin
          head_q[i] <= head_q[i] + TW'(1);
          cnt_q[i] <= cnt_q[i] - CW'(1);
        end else if (push_en && push_l == LW'(i)) begin
          cnt_q[i] <= cnt_q[i] + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bid_we) bids_q[bn_q[TW-1:0]] <= qm_rdata;
  end

  // Picking a task in StPickRd changes held_q, so the run step must read the new
  // entry; the memory read in StPickRd covers that because tk_raddr follows qm_rdata.
  assign busy = (state_q != StIdle);
  assign ran_task_o = hv_q ? 4'(held_q) : 4'd0;
  assign idle_o = !hv_q;
  assign finished_o = hv_q && (tk_wrem == 16'd0);
  assign demoted_o = dem_q;
  assign ran_level_o = hv_q ? 3'(tk_rlvl) : 3'd0;
  assign boosted_o = boost_q;

endmodule
